// ===== rtl/tss_pkg.sv =====
package tss_pkg;

	localparam int NUM_TASKS_DEF      = 8;
	localparam int RING_DEPTH_DEF     = 8;
	localparam int NUM_SEMAPHORES_DEF = 4;

	localparam int OP_W       = 3;
	localparam int MS_W       = 16;
	localparam int SEM_SEL_W  = 2;
	localparam int TASK_OUT_W = 3;
	localparam int CNT_W      = 9;
	localparam int TICK_W     = 32;
	localparam int RATE_W     = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int SLEEP_W    = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 1'd0;
	localparam logic [RATE_W-1:0]    RATE_RESET    = 10'd100;
	localparam logic [CNT_W-1:0]     SEM_RESET     = 9'd1;
	localparam int                   COUNT_MAX     = 255;

	localparam int MS_PER_SEC  = 1000;
	localparam int SLEEP_MAX   = 65535;
	localparam int PROD_W      = MS_W + RATE_W;
	localparam int RECIP_SHIFT = 36;
	localparam int RECIP_W     = 27;
	localparam int QUO_W       = 17;
	localparam int RPROD_W     = PROD_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_MULT =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(MS_PER_SEC) - 64'd1) / 64'(MS_PER_SEC));

	typedef enum logic [OP_W-1:0] {
		OP_YIELD = 3'd0,
		OP_SLEEP = 3'd1,
		OP_SEM_P = 3'd2,
		OP_SEM_V = 3'd3,
		OP_TICK  = 3'd4
	} op_t;

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic sleep_wr;
		logic yield_start;
		logic yield_step;
		logic yield_take;
		logic set_none;
		logic sem_dec;
		logic sem_inc;
		logic enqueue;
		logic ring_rd;
		logic wake;
		logic tick;
		logic out_load;
	} tss_cmd_t;

	typedef struct packed {
		logic is_yield;
		logic is_sleep;
		logic is_p;
		logic is_v;
		logic is_tick;
		logic sem_ok;
		logic p_ok;
		logic p_enq;
		logic v_ok;
		logic v_deq;
		logic cand_ready;
		logic cand_last;
	} tss_status_t;

endpackage

// ===== rtl/tss_ctrl.sv =====
module tss_ctrl
	import tss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  tss_status_t status,
	output tss_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_MUL1,
		S_MUL2,
		S_SLEEP_WR,
		S_YIELD,
		S_WAKE,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_DONE;
				if (status.is_yield) begin
					cmd.yield_start = 1'b1;
					state_d         = S_YIELD;
				end else if (status.is_sleep) begin
					state_d = S_MUL1;
				end else if (status.is_p && status.sem_ok && status.p_ok) begin
					cmd.sem_dec = 1'b1;
					if (status.p_enq) begin
						cmd.enqueue     = 1'b1;
						cmd.yield_start = 1'b1;
						state_d         = S_YIELD;
					end
				end else if (status.is_v && status.sem_ok && status.v_ok) begin
					cmd.sem_inc = 1'b1;
					if (status.v_deq) begin
						cmd.ring_rd = 1'b1;
						state_d     = S_WAKE;
					end
				end else if (status.is_tick) begin
					cmd.tick = 1'b1;
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_SLEEP_WR;
			end
			S_SLEEP_WR: begin
				cmd.sleep_wr    = 1'b1;
				cmd.yield_start = 1'b1;
				state_d         = S_YIELD;
			end
			S_YIELD: begin
				if (status.cand_ready) begin
					cmd.yield_take = 1'b1;
					state_d        = S_DONE;
				end else if (status.cand_last) begin
					cmd.set_none = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.yield_step = 1'b1;
				end
			end
			S_WAKE: begin
				cmd.wake = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/tss_dpath.sv =====
module tss_dpath
	import tss_pkg::*;
#(
	parameter int NUM_TASKS      = NUM_TASKS_DEF,
	parameter int RING_DEPTH     = RING_DEPTH_DEF,
	parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [RATE_W-1:0]       cfg_data,
	input  logic [OP_W-1:0]         op,
	input  logic [MS_W-1:0]         sleep_ms,
	input  logic [SEM_SEL_W-1:0]    sem_index,
	input  tss_cmd_t                cmd,
	output tss_status_t             status,
	output logic [TASK_OUT_W-1:0]   running_task,
	output logic                    none_ready,
	output logic signed [CNT_W-1:0] sem_count,
	output logic [TICK_W-1:0]       tick_count
);

	localparam int TASK_W    = $clog2(NUM_TASKS);
	localparam int RING_W    = $clog2(RING_DEPTH);
	localparam int SEM_IDX_W = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
	localparam int RING_N    = NUM_SEMAPHORES * RING_DEPTH;
	localparam int RING_AW   = $clog2(RING_N);
	localparam logic signed [CNT_W-1:0] SEM_MIN = CNT_W'(-RING_DEPTH);
	localparam logic signed [CNT_W-1:0] SEM_MAX = CNT_W'(COUNT_MAX);

	logic [OP_W-1:0]      op_q;
	logic [MS_W-1:0]      ms_q;
	logic [SEM_SEL_W-1:0] si_q;
	logic [RATE_W-1:0]    rate_q;
	logic [PROD_W-1:0]    prod_q;
	logic [QUO_W-1:0]     quo_q;
	logic [TASK_W-1:0]    cur_q;
	logic [TASK_W-1:0]    cand_q;
	logic [TASK_W-1:0]    rd_q;
	logic                 none_q;
	logic [TICK_W-1:0]    ticks_q;

	logic [SLEEP_W-1:0]          sleep_q [NUM_TASKS];
	logic [NUM_TASKS-1:0]        wait_q;
	logic signed [CNT_W-1:0]     sem_q   [NUM_SEMAPHORES];
	logic [RING_W-1:0]           head_q  [NUM_SEMAPHORES];
	logic [RING_W-1:0]           tail_q  [NUM_SEMAPHORES];
	logic [TASK_W-1:0]           ring_mem [RING_N];

	logic [TASK_OUT_W-1:0]   running_task_q;
	logic                    none_ready_q;
	logic signed [CNT_W-1:0] sem_count_q;
	logic [TICK_W-1:0]       tick_count_q;

	logic                    sem_ok;
	logic [SEM_IDX_W-1:0]    sidx;
	logic signed [CNT_W-1:0] sem_cur;
	logic [RING_W-1:0]       head_cur;
	logic [RING_W-1:0]       tail_cur;
	logic [RING_AW-1:0]      rd_addr;
	logic [RING_AW-1:0]      wr_addr;
	logic [TASK_W-1:0]       cur_next;
	logic [TASK_W-1:0]       cand_next;
	logic [RPROD_W-1:0]      recip_prod;
	logic [SLEEP_W-1:0]      sleep_val;

	function automatic logic [RING_W-1:0] ring_inc(input logic [RING_W-1:0] p);
		ring_inc = (p == RING_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign sem_ok    = 32'(si_q) < NUM_SEMAPHORES;
	assign sidx      = SEM_IDX_W'(si_q);
	assign sem_cur   = sem_ok ? sem_q[sidx] : '0;
	assign head_cur  = sem_ok ? head_q[sidx] : '0;
	assign tail_cur  = sem_ok ? tail_q[sidx] : '0;
	assign rd_addr   = RING_AW'(32'(sidx) * RING_DEPTH + 32'(head_cur));
	assign wr_addr   = RING_AW'(32'(sidx) * RING_DEPTH + 32'(tail_cur));
	assign cur_next  = (cur_q == TASK_W'(NUM_TASKS - 1)) ? '0 : cur_q + 1'b1;
	assign cand_next = (cand_q == TASK_W'(NUM_TASKS - 1)) ? '0 : cand_q + 1'b1;

	assign recip_prod = RPROD_W'(prod_q) * RPROD_W'(RECIP_MULT);
	assign sleep_val  = (quo_q > QUO_W'(SLEEP_MAX)) ? SLEEP_W'(SLEEP_MAX) : quo_q[SLEEP_W-1:0];

	always_comb begin
		status            = '0;
		status.is_yield   = (op_q == OP_YIELD);
		status.is_sleep   = (op_q == OP_SLEEP);
		status.is_p       = (op_q == OP_SEM_P);
		status.is_v       = (op_q == OP_SEM_V);
		status.is_tick    = (op_q == OP_TICK);
		status.sem_ok     = sem_ok;
		status.p_ok       = sem_cur > SEM_MIN;
		status.p_enq      = sem_cur <= 0;
		status.v_ok       = sem_cur < SEM_MAX;
		status.v_deq      = sem_cur < 0;
		status.cand_ready = (sleep_q[cand_q] == '0) && !wait_q[cand_q];
		status.cand_last  = (cand_q == cur_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			ms_q <= sleep_ms;
			si_q <= sem_index;
		end
		if (cmd.mul1) begin
			prod_q <= PROD_W'(ms_q) * PROD_W'(rate_q);
		end
		if (cmd.mul2) begin
			quo_q <= recip_prod[RECIP_SHIFT +: QUO_W];
		end
		if (cmd.yield_start) begin
			cand_q <= cur_next;
		end else if (cmd.yield_step) begin
			cand_q <= cand_next;
		end
		if (cmd.load) begin
			none_q <= 1'b0;
		end else if (cmd.set_none) begin
			none_q <= 1'b1;
		end
		if (cmd.out_load) begin
			running_task_q <= TASK_OUT_W'(cur_q);
			none_ready_q   <= none_q;
			sem_count_q    <= sem_cur;
			tick_count_q   <= ticks_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enqueue) begin
			ring_mem[wr_addr] <= cur_q;
		end
		if (cmd.ring_rd) begin
			rd_q <= ring_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q  <= RATE_RESET;
			cur_q   <= '0;
			wait_q  <= '0;
			ticks_q <= '0;
			for (int i = 0; i < NUM_TASKS; i++) begin
				sleep_q[i] <= '0;
			end
			for (int s = 0; s < NUM_SEMAPHORES; s++) begin
				sem_q[s]  <= SEM_RESET;
				head_q[s] <= '0;
				tail_q[s] <= '0;
			end
		end else begin
			if (cfg_wr_en && cfg_index == CFG_TICK_RATE) begin
				rate_q <= cfg_data;
			end
			if (cmd.sleep_wr) begin
				sleep_q[cur_q] <= sleep_val;
			end
			if (cmd.tick) begin
				for (int i = 0; i < NUM_TASKS; i++) begin
					if (sleep_q[i] != '0) begin
						sleep_q[i] <= sleep_q[i] - 1'b1;
					end
				end
				ticks_q <= ticks_q + 1'b1;
			end
			if (cmd.yield_take) begin
				cur_q <= cand_q;
			end
			if (cmd.sem_dec) begin
				sem_q[sidx] <= sem_q[sidx] - CNT_W'(1);
			end
			if (cmd.sem_inc) begin
				sem_q[sidx] <= sem_q[sidx] + CNT_W'(1);
			end
			if (cmd.enqueue) begin
				wait_q[cur_q] <= 1'b1;
				tail_q[sidx]  <= ring_inc(tail_q[sidx]);
			end
			if (cmd.wake) begin
				cur_q        <= rd_q;
				wait_q[rd_q] <= 1'b0;
				head_q[sidx] <= ring_inc(head_q[sidx]);
			end
		end
	end

	assign running_task = running_task_q;
	assign none_ready   = none_ready_q;
	assign sem_count    = sem_count_q;
	assign tick_count   = tick_count_q;

endmodule

// ===== rtl/task_scheduler_with_semaphores.sv =====
// A tick, P, V or bad op goes from dispatch straight to done; a V that wakes a waiter
// passes the wake state first; a yield or blocking P runs the ready scan, and a sleep
// first passes MUL1, MUL2 and SLEEP_WR; the scan visits 1 to NUM_TASKS tasks, one per cycle.
// One item at a time; the next item is accepted once the result sits in the output register.
// Reset (arst_n low, asynchronous) clears all tasks, sets semaphores to 1 and rate to 100.
module task_scheduler_with_semaphores
	import tss_pkg::*;
#(
	parameter int NUM_TASKS      = NUM_TASKS_DEF,
	parameter int RING_DEPTH     = RING_DEPTH_DEF,
	parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [RATE_W-1:0]       cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [OP_W-1:0]         op,
	input  logic [MS_W-1:0]         sleep_ms,
	input  logic [SEM_SEL_W-1:0]    sem_index,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [TASK_OUT_W-1:0]   running_task,
	output logic                    none_ready,
	output logic signed [CNT_W-1:0] sem_count,
	output logic [TICK_W-1:0]       tick_count
);

	tss_cmd_t    cmd;
	tss_status_t status;

	tss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	tss_dpath #(
		.NUM_TASKS      (NUM_TASKS),
		.RING_DEPTH     (RING_DEPTH),
		.NUM_SEMAPHORES (NUM_SEMAPHORES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (op),
		.sleep_ms     (sleep_ms),
		.sem_index    (sem_index),
		.cmd          (cmd),
		.status       (status),
		.running_task (running_task),
		.none_ready   (none_ready),
		.sem_count    (sem_count),
		.tick_count   (tick_count)
	);

endmodule
